@@ hdl/fmpp_pkg.sv @@
// Package for the FFT magnitude, phase and peak block.
// Holds sizes, item types, the arctangent table and the twiddle tables.
// No dependencies; every other file of the block but fmpp_stream_if imports it.
package fmpp_pkg;

  localparam int FFT_POINTS   = 128;
  localparam int PHASE_BITS   = 16;
  localparam int BINS         = FFT_POINTS / 2;
  localparam int IDX_W        = $clog2(FFT_POINTS);
  localparam int BIN_W        = 6;
  localparam int CORDIC_STEPS = 28;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam longint CORDIC_X0 = 652032874;
  localparam logic [BIN_W-1:0] SKIP_RESET = BIN_W'(10);
  localparam int ACC_W        = 56;
  localparam int FRAC_SHIFT   = 22;
  localparam int Q8_W         = ACC_W - FRAC_SHIFT;
  localparam int PROD_W       = 49;
  localparam int CX_W         = 36;
  localparam int CZ_W         = 34;
  localparam int DIV_SHIFT    = 8 + $clog2(FFT_POINTS);

  localparam int ATAN_TAB [CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
  };

  typedef logic signed [31:0] tw_tab_t [FFT_POINTS];

  typedef struct packed {
    logic [15:0] tx_sample;
    logic [15:0] rx_sample;
  } in_item_t;

  typedef struct packed {
    logic [5:0]          bin_index;
    logic [16:0]         rx_magnitude;
    logic signed [15:0]  rx_phase;
    logic signed [15:0]  tx_phase;
    logic [5:0]          peak_bin;
    logic                last_bin;
  } out_item_t;

  typedef struct packed {
    logic [BIN_W-1:0]       bin;
    logic signed [Q8_W-1:0] rx_re;
    logic signed [Q8_W-1:0] rx_im;
    logic signed [Q8_W-1:0] tx_re;
    logic signed [Q8_W-1:0] tx_im;
  } bin_sums_t;

  // Rotation CORDIC over one turn in 2^32 units, cos or sin in Q30.
  function automatic tw_tab_t gen_tw(input bit want_sin);
    tw_tab_t tab;
    longint  t;
    longint  x;
    longint  y;
    longint  nx;
    longint  ny;
    bit      neg;
    for (int m = 0; m < FFT_POINTS; m++) begin
      t   = (longint'(m) <<< 32) / FFT_POINTS;
      neg = 1'b0;
      x   = CORDIC_X0;
      y   = 0;
      if (t >= (longint'(1) <<< 31)) t = t - (longint'(1) <<< 32);
      if (t > (longint'(1) <<< 30)) begin
        t   = t - (longint'(1) <<< 31);
        neg = 1'b1;
      end else if (t < -(longint'(1) <<< 30)) begin
        t   = t + (longint'(1) <<< 31);
        neg = 1'b1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (t >= 0) begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          t  = t - longint'(ATAN_TAB[i]);
        end else begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          t  = t + longint'(ATAN_TAB[i]);
        end
        x = nx;
        y = ny;
      end
      if (neg) begin
        x = -x;
        y = -y;
      end
      tab[m] = want_sin ? 32'(y) : 32'(x);
    end
    return tab;
  endfunction

  localparam tw_tab_t TW_COS = gen_tw(1'b0);
  localparam tw_tab_t TW_SIN = gen_tw(1'b1);

endpackage

@@ hdl/fmpp_stream_if.sv @@
// Valid/ready stream interface used by every channel of the block.
// Payload type is set per instance; no other dependencies.
interface fmpp_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/fmpp_front.sv @@
// Front part: loads a frame into two sample memories, then runs a
// multiply-accumulate pass per bin and hands the bin sums on.
// Depends on fmpp_pkg and fmpp_stream_if.
module fmpp_front import fmpp_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  fmpp_stream_if.sink    in_i,
  fmpp_stream_if.source  sums_o
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] n_q, n_d;
  logic [IDX_W-1:0] m_q, m_d;
  logic [BIN_W-1:0] k_q, k_d;
  logic             issue_q, issue_d;
  logic             s1_v_q, s1_last_q, s1_first_q, s1_odd_q;
  logic             s2_v_q, s2_last_q, s2_first_q;

  logic [15:0] tx_mem [FFT_POINTS];
  logic [15:0] rx_mem [FFT_POINTS];
  logic [15:0] rd_tx_q, rd_rx_q;
  logic signed [31:0] tw_c_q, tw_s_q;
  logic signed [PROD_W-1:0] p_rr_q, p_ri_q, p_tr_q, p_ti_q;
  logic signed [PROD_W-1:0] p_rr_d, p_ri_d, p_tr_d, p_ti_d;
  logic signed [ACC_W-1:0]  a_rr_q, a_ri_q, a_tr_q, a_ti_q;
  logic signed [PROD_W-1:0] rx_dc, tx_dc;
  logic                     do_issue, accept;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_LOAD);
  assign do_issue = (state_q == ST_RUN) && issue_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    m_d     = m_q;
    k_d     = k_q;
    issue_d = issue_q;
    unique case (state_q)
      ST_LOAD: begin
        if (accept) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == IDX_W'(FFT_POINTS - 1)) begin
            state_d = ST_RUN;
            issue_d = 1'b1;
            n_d     = '0;
            m_d     = '0;
            k_d     = '0;
          end
        end
      end
      ST_RUN: begin
        if (issue_q) begin
          n_d = n_q + 1'b1;
          m_d = m_q + IDX_W'(k_q);
          if (n_q == IDX_W'(FFT_POINTS - 1)) issue_d = 1'b0;
        end
        if (s2_v_q && s2_last_q) state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (sums_o.ready) begin
          if (k_q == BIN_W'(BINS - 1)) begin
            state_d = ST_LOAD;
            k_d     = '0;
          end else begin
            state_d = ST_RUN;
            k_d     = k_q + 1'b1;
            issue_d = 1'b1;
            n_d     = '0;
            m_d     = '0;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      n_q     <= '0;
      m_q     <= '0;
      k_q     <= '0;
      issue_q <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      m_q     <= m_d;
      k_q     <= k_d;
      issue_q <= issue_d;
      s1_v_q  <= do_issue;
      s2_v_q  <= s1_v_q;
    end
  end

  // Bin zero: DC as real part, alternating sum as imaginary part, both in Q8.
  assign rx_dc = PROD_W'($signed({1'b0, rd_rx_q, 8'b0}));
  assign tx_dc = PROD_W'($signed({1'b0, rd_tx_q, 8'b0}));

  always_comb begin
    if (k_q == '0) begin
      p_rr_d = rx_dc;
      p_tr_d = tx_dc;
      p_ri_d = s1_odd_q ? -rx_dc : rx_dc;
      p_ti_d = s1_odd_q ? -tx_dc : tx_dc;
    end else begin
      p_rr_d = $signed({1'b0, rd_rx_q}) * tw_c_q;
      p_tr_d = $signed({1'b0, rd_tx_q}) * tw_c_q;
      p_ri_d = -($signed({1'b0, rd_rx_q}) * tw_s_q);
      p_ti_d = -($signed({1'b0, rd_tx_q}) * tw_s_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tx_mem[cnt_q] <= in_i.data.tx_sample;
      rx_mem[cnt_q] <= in_i.data.rx_sample;
    end
    rd_tx_q    <= tx_mem[n_q];
    rd_rx_q    <= rx_mem[n_q];
    tw_c_q     <= TW_COS[m_q];
    tw_s_q     <= TW_SIN[m_q];
    s1_last_q  <= (n_q == IDX_W'(FFT_POINTS - 1));
    s1_first_q <= (n_q == '0);
    s1_odd_q   <= n_q[0];
    s2_last_q  <= s1_last_q;
    s2_first_q <= s1_first_q;
    p_rr_q     <= p_rr_d;
    p_ri_q     <= p_ri_d;
    p_tr_q     <= p_tr_d;
    p_ti_q     <= p_ti_d;
    if (s2_v_q) begin
      a_rr_q <= (s2_first_q ? '0 : a_rr_q) + ACC_W'(p_rr_q);
      a_ri_q <= (s2_first_q ? '0 : a_ri_q) + ACC_W'(p_ri_q);
      a_tr_q <= (s2_first_q ? '0 : a_tr_q) + ACC_W'(p_tr_q);
      a_ti_q <= (s2_first_q ? '0 : a_ti_q) + ACC_W'(p_ti_q);
    end
  end

  // Q30 sums drop to Q8 by floor; bin zero is already in Q8.
  assign sums_o.valid      = (state_q == ST_PUSH);
  assign sums_o.data.bin   = k_q;
  assign sums_o.data.rx_re = (k_q == '0) ? a_rr_q[Q8_W-1:0] : a_rr_q[ACC_W-1:FRAC_SHIFT];
  assign sums_o.data.rx_im = (k_q == '0) ? a_ri_q[Q8_W-1:0] : a_ri_q[ACC_W-1:FRAC_SHIFT];
  assign sums_o.data.tx_re = (k_q == '0) ? a_tr_q[Q8_W-1:0] : a_tr_q[ACC_W-1:FRAC_SHIFT];
  assign sums_o.data.tx_im = (k_q == '0) ? a_ti_q[Q8_W-1:0] : a_ti_q[ACC_W-1:FRAC_SHIFT];

endmodule

@@ hdl/fmpp_queue.sv @@
// Two-entry queue of bin sums between the front and the back part.
// Depends on fmpp_pkg and fmpp_stream_if.
module fmpp_queue import fmpp_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  fmpp_stream_if.sink    wr_i,
  fmpp_stream_if.source  rd_o
);

  bin_sums_t  ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_i.ready = (cnt_q != 2'd2);
  assign rd_o.valid = (cnt_q != 2'd0);
  assign rd_o.data  = ent_q[rp_q];
  assign push = wr_i.valid && wr_i.ready;
  assign pop  = rd_o.valid && rd_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wp_q] <= wr_i.data;
  end

endmodule

@@ hdl/fmpp_cordic.sv @@
// Vectoring CORDIC, one step a cycle: phase of a Q8 vector as a signed code.
// Depends on fmpp_pkg.
module fmpp_cordic import fmpp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [Q8_W-1:0] re_i,
  input  logic signed [Q8_W-1:0] im_i,
  output logic                   done_o,
  output logic signed [15:0]     phase_o
);

  localparam logic signed [CZ_W-1:0] HALF_TURN = CZ_W'(64'h8000_0000);

  logic signed [CX_W-1:0] x_q, y_q;
  logic signed [CZ_W-1:0] z_q;
  logic [STEP_W-1:0]      i_q;
  logic                   busy_q, done_q, zero_q;
  logic signed [CZ_W-1:0] ang;
  logic signed [31:0]     vs;

  assign ang = CZ_W'(ATAN_TAB[i_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      i_q    <= '0;
    end else if (busy_q) begin
      i_q <= i_q + 1'b1;
      if (i_q == STEP_W'(CORDIC_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (re_i == '0) && (im_i == '0);
      // Left half plane: turn by half a turn first.
      if (re_i < 0) begin
        x_q <= -CX_W'(re_i);
        y_q <= -CX_W'(im_i);
        z_q <= HALF_TURN;
      end else begin
        x_q <= CX_W'(re_i);
        y_q <= CX_W'(im_i);
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + (y_q >>> i_q);
        y_q <= y_q - (x_q >>> i_q);
        z_q <= z_q + ang;
      end else begin
        x_q <= x_q - (y_q >>> i_q);
        y_q <= y_q + (x_q >>> i_q);
        z_q <= z_q - ang;
      end
    end
  end

  assign vs      = $signed(z_q[31:0]) >>> (32 - PHASE_BITS);
  assign done_o  = done_q;
  assign phase_o = zero_q ? 16'sd0 : vs[15:0];

endmodule

@@ hdl/fmpp_back.sv @@
// Back part: magnitude by squares and a bit-serial square root, two phase
// CORDICs, peak tracking and the output register.
// Depends on fmpp_pkg, fmpp_stream_if and fmpp_cordic.
module fmpp_back import fmpp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [BIN_W-1:0] skip_i,
  fmpp_stream_if.sink      sums_i,
  fmpp_stream_if.source    out_o
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_SQ0  = 3'd1;
  localparam logic [2:0] B_SQ1  = 3'd2;
  localparam logic [2:0] B_SQ2  = 3'd3;
  localparam logic [2:0] B_ROOT = 3'd4;
  localparam logic [2:0] B_EMIT = 3'd5;

  logic [2:0]       state_q;
  logic [BIN_W-1:0] k_q;
  logic [31:0]      ar_q, ai_q, mul_a;
  logic [63:0]      sq, prod_q, rad_q, root_q, bit_q, trial;
  logic             take, emit, out_v_q;
  logic             rx_done, tx_done;
  logic signed [15:0] rx_ph, tx_ph;
  logic signed [Q8_W-1:0] rr_abs, ri_abs;
  logic [16:0]      mag, pv_base, pv_new, peak_val_q;
  logic [BIN_W-1:0] pp_base, pp_new, peak_pos_q;
  logic             hit, is_last;
  out_item_t        out_q;

  assign take = (state_q == B_IDLE) && sums_i.valid;
  assign sums_i.ready = (state_q == B_IDLE);
  assign emit = (state_q == B_EMIT) && rx_done && tx_done && (!out_v_q || out_o.ready);

  assign rr_abs = (sums_i.data.rx_re < 0) ? -sums_i.data.rx_re : sums_i.data.rx_re;
  assign ri_abs = (sums_i.data.rx_im < 0) ? -sums_i.data.rx_im : sums_i.data.rx_im;

  fmpp_cordic u_rx_cordic (
    .clk_i, .rst_ni, .start_i(take),
    .re_i(sums_i.data.rx_re), .im_i(sums_i.data.rx_im),
    .done_o(rx_done), .phase_o(rx_ph)
  );

  fmpp_cordic u_tx_cordic (
    .clk_i, .rst_ni, .start_i(take),
    .re_i(sums_i.data.tx_re), .im_i(sums_i.data.tx_im),
    .done_o(tx_done), .phase_o(tx_ph)
  );

  assign mul_a = (state_q == B_SQ0) ? ar_q : ai_q;
  assign sq    = mul_a * mul_a;
  assign trial = root_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_IDLE;
      out_v_q    <= 1'b0;
      peak_val_q <= '0;
      peak_pos_q <= '0;
    end else begin
      if (emit) begin
        out_v_q    <= 1'b1;
        peak_val_q <= pv_new;
        peak_pos_q <= pp_new;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: if (take) state_q <= B_SQ0;
        B_SQ0:  state_q <= B_SQ1;
        B_SQ1:  state_q <= B_SQ2;
        B_SQ2:  state_q <= B_ROOT;
        B_ROOT: if (bit_q[1:0] != 2'b00) state_q <= B_EMIT;
        B_EMIT: if (emit) state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        k_q  <= sums_i.data.bin;
        ar_q <= rr_abs[31:0];
        ai_q <= ri_abs[31:0];
      end
      B_SQ0: prod_q <= sq;
      B_SQ1: begin
        rad_q  <= prod_q;
        prod_q <= sq;
      end
      B_SQ2: begin
        rad_q  <= rad_q + prod_q;
        root_q <= '0;
        bit_q  <= 64'h4000_0000_0000_0000;
      end
      B_ROOT: begin
        // One result bit a step; all 32 steps run.
        if (rad_q >= trial) begin
          rad_q  <= rad_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      B_EMIT: begin
        if (emit) out_q <= '{bin_index: k_q, rx_magnitude: mag, rx_phase: rx_ph,
                             tx_phase: tx_ph, peak_bin: is_last ? pp_new : '0,
                             last_bin: is_last};
      end
      default: ;
    endcase
  end

  // Restart the peak search on bin zero.
  assign mag     = 17'(root_q >> DIV_SHIFT);
  assign pv_base = (k_q == '0) ? '0 : peak_val_q;
  assign pp_base = (k_q == '0) ? '0 : peak_pos_q;
  assign hit     = (mag > pv_base) && (k_q > skip_i);
  assign pv_new  = hit ? mag : pv_base;
  assign pp_new  = hit ? k_q : pp_base;
  assign is_last = (k_q == BIN_W'(BINS - 1));

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

endmodule

@@ hdl/fft_magnitude_phase_peak_top.sv @@
// Top level of the FFT magnitude, phase and peak block.
// Depends on fmpp_pkg, fmpp_stream_if, fmpp_front, fmpp_queue, fmpp_back.
//
// Usage:
//   in_i carries one transmit/receive sample pair per beat. After the 128th
//   beat of a frame the block stops taking samples and transforms the frame,
//   then emits 64 result beats on out_o, bins 0 to 63 in order. The last
//   beat has last_bin set and carries the peak bin of the frame.
//   cfg_we_i writes cfg_data_i into the peak skip register (reset 10).
// Throughput: samples load at one a cycle while a frame is being taken in;
//   the transform then runs one multiply-accumulate per sample per cycle in
//   the front pass, one pass per bin. The magnitude and phase work for a bin
//   overlaps the next bin's pass through a two-entry queue.
// Reset: empties the frame count, queue and output register; the skip
//   register returns to 10. Sample memories hold no reset value.
// Stall: a held output beat stalls the back part, then the queue, then the
//   front pass; no result is lost.
module fft_magnitude_phase_peak_top import fmpp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [BIN_W-1:0] cfg_data_i,
  fmpp_stream_if.sink      in_i,
  fmpp_stream_if.source    out_o
);

  logic [BIN_W-1:0] skip_q;

  fmpp_stream_if #(.T(bin_sums_t)) sums_a ();
  fmpp_stream_if #(.T(bin_sums_t)) sums_b ();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= SKIP_RESET;
    end else if (cfg_we_i) begin
      skip_q <= cfg_data_i;
    end
  end

  fmpp_front u_front (.clk_i, .rst_ni, .in_i(in_i), .sums_o(sums_a));
  fmpp_queue u_queue (.clk_i, .rst_ni, .wr_i(sums_a), .rd_o(sums_b));
  fmpp_back  u_back  (.clk_i, .rst_ni, .skip_i(skip_q), .sums_i(sums_b), .out_o(out_o));

endmodule

@@ hdl/fmpp_checker.sv @@
// Port-level checker for the FFT magnitude, phase and peak block,
// bound to the top level. Depends on fmpp_pkg.
module fmpp_checker import fmpp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result beat changed while stalled");

  a_last_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.last_bin |-> out_data.bin_index == 6'(BINS - 1))
    else $error("last flag on wrong bin");

  a_peak_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data.last_bin |-> out_data.peak_bin == '0)
    else $error("peak bin shown before last result");

endmodule

bind fft_magnitude_phase_peak_top fmpp_checker u_fmpp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.data)
);

@@ bench/tb.sv @@
// Testbench for fft_magnitude_phase_peak_top: loads sample frames, predicts each bin beat.
// The spectrum, phase and peak predictor below is independent of the RTL tables.
// Depends on fmpp_pkg, fmpp_stream_if and fft_magnitude_phase_peak_top.
`timescale 1ns / 100ps

module tb;
  import fmpp_pkg::*;

  localparam int NPTS       = 128;
  localparam int NBINS      = NPTS / 2;
  localparam int ROT_STEPS  = 28;
  localparam int CYCLE_CAP  = 1500000;
  localparam int DRAIN_WAIT = 400;

  typedef logic [15:0] frame_t [NPTS];

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [BIN_W-1:0] cfg_data_i = '0;

  fmpp_stream_if #(.T(in_item_t))  sample_if ();
  fmpp_stream_if #(.T(out_item_t)) bin_if ();

  fft_magnitude_phase_peak_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (sample_if),
    .out_o      (bin_if)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state
  longint    cos_q30 [NPTS];
  longint    sin_q30 [NPTS];
  longint    arc_step [ROT_STEPS];
  frame_t    tx_buf;
  frame_t    rx_buf;
  int        fill_count;
  logic [5:0] skip_bins;
  out_item_t expected_bins [$];

  int  mismatches;
  int  cycle_count;
  bit  gaps_on;
  bit  stalls_on;
  int  hold_left;
  int  stall_left;

  initial begin
    sample_if.valid = 1'b0;
    sample_if.data  = '0;
    bin_if.ready    = 1'b0;
  end

  function automatic void build_twiddles();
    longint t, x, y, nx, ny;
    bit     flip;
    arc_step = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                 81, 41, 20, 10, 5};
    for (int m = 0; m < NPTS; m++) begin
      t = (longint'(m) <<< 32) / NPTS;
      flip = 1'b0;
      x = 652032874;
      y = 0;
      if (t >= (longint'(1) <<< 31)) t -= (longint'(1) <<< 32);
      if (t > (longint'(1) <<< 30)) begin
        t -= (longint'(1) <<< 31);
        flip = 1'b1;
      end else if (t < -(longint'(1) <<< 30)) begin
        t += (longint'(1) <<< 31);
        flip = 1'b1;
      end
      for (int i = 0; i < ROT_STEPS; i++) begin
        if (t >= 0) begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          t -= arc_step[i];
        end else begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          t += arc_step[i];
        end
        x = nx;
        y = ny;
      end
      cos_q30[m] = flip ? -x : x;
      sin_q30[m] = flip ? -y : y;
    end
  endfunction

  // Q8 real and imaginary sums of one bin; bin 0 packs DC and Nyquist.
  function automatic void bin_q8(input frame_t fr, input int k,
                                 output longint re, output longint im);
    longint sr, si, s;
    int     m;
    sr = 0;
    si = 0;
    for (int n = 0; n < NPTS; n++) begin
      s = longint'({48'd0, fr[n]});
      if (k == 0) begin
        sr += s;
        si += n[0] ? -s : s;
      end else begin
        m = (k * n) % NPTS;
        sr += s * cos_q30[m];
        si -= s * sin_q30[m];
      end
    end
    if (k == 0) begin
      re = sr * 256;
      im = si * 256;
    end else begin
      re = sr >>> 22;
      im = si >>> 22;
    end
  endfunction

  function automatic logic signed [15:0] angle_of(input longint re, input longint im);
    longint x, y, z, nx, ny;
    if (re == 0 && im == 0) return '0;
    x = re;
    y = im;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = longint'(1) <<< 31;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += arc_step[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= arc_step[i];
      end
      x = nx;
      y = ny;
    end
    return z[31:16];
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Add one accepted sample; a full frame queues all of its bin beats.
  function automatic void absorb_sample(input in_item_t s);
    longint          rr, ri, tr, ti;
    longint unsigned ar, ai, mag, best;
    logic [5:0]      best_bin;
    out_item_t       e;
    tx_buf[fill_count] = s.tx_sample;
    rx_buf[fill_count] = s.rx_sample;
    fill_count++;
    if (fill_count < NPTS) return;
    fill_count = 0;
    best = 0;
    best_bin = '0;
    for (int k = 0; k < NBINS; k++) begin
      bin_q8(rx_buf, k, rr, ri);
      bin_q8(tx_buf, k, tr, ti);
      ar  = rr < 0 ? -rr : rr;
      ai  = ri < 0 ? -ri : ri;
      mag = (floor_sqrt(ar * ar + ai * ai) / (256 * NPTS)) & 64'h1FFFF;
      if (mag > best && k > skip_bins) begin
        best = mag;
        best_bin = k[5:0];
      end
      e.bin_index    = k[5:0];
      e.rx_magnitude = mag[16:0];
      e.rx_phase     = angle_of(rr, ri);
      e.tx_phase     = angle_of(tr, ti);
      e.last_bin     = (k == NBINS - 1);
      e.peak_bin     = e.last_bin ? best_bin : '0;
      expected_bins.push_back(e);
    end
  endfunction

  task automatic send_sample(input logic [15:0] tx, input logic [15:0] rx);
    in_item_t d;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      sample_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    d.tx_sample = tx;
    d.rx_sample = rx;
    sample_if.valid <= 1'b1;
    sample_if.data  <= d;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    absorb_sample(d);
  endtask

  task automatic wait_drained();
    sample_if.valid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_skip(input logic [5:0] v);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    skip_bins = v;
  endtask

  task automatic send_random_frame();
    for (int n = 0; n < NPTS; n++) begin
      case ($urandom_range(0, 3))
        0:       send_sample(16'($urandom), 16'($urandom));
        1:       send_sample(16'($urandom_range(0, 255)),
                             16'(16'hFFFF - $urandom_range(0, 255)));
        default: send_sample(16'(16'h8000 + $urandom_range(0, 4095) * ((n % 8) < 4)),
                             16'($urandom_range(0, 65535) >> $urandom_range(0, 15)));
      endcase
    end
  endtask

  // Full-scale alternation drives Nyquist to its extreme and DC to half scale.
  task automatic test_extreme_frame();
    write_skip(6'd0);
    for (int n = 0; n < NPTS; n++)
      send_sample(n[0] ? 16'hFFFF : 16'h0000, n[0] ? 16'h0000 : 16'hFFFF);
  endtask

  // Hold the result side while the next frame is offered at full rate.
  task automatic test_backpressure();
    hold_left = 20000;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_random_frame();
  endtask

  // Result side ready: random stall bursts and the long hold-off.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      bin_if.ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      bin_if.ready <= 1'b0;
      stall_left--;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      bin_if.ready <= 1'b0;
      stall_left = $urandom_range(0, 9);
    end else begin
      bin_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    out_item_t e;
    out_item_t a;
    if (rst_ni && bin_if.valid && bin_if.ready) begin
      a = bin_if.data;
      if (expected_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: bin %0d", a.bin_index);
      end else begin
        e = expected_bins.pop_front();
        if (a.bin_index !== e.bin_index || a.rx_magnitude !== e.rx_magnitude ||
            a.rx_phase !== e.rx_phase || a.tx_phase !== e.tx_phase ||
            a.peak_bin !== e.peak_bin || a.last_bin !== e.last_bin) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch bin %0d: exp mag %0d rxph %0d txph %0d peak %0d last %0b",
                     e.bin_index, e.rx_magnitude, e.rx_phase, e.tx_phase,
                     e.peak_bin, e.last_bin,
                     " / got bin %0d mag %0d rxph %0d txph %0d peak %0d last %0b",
                     a.bin_index, a.rx_magnitude, a.rx_phase, a.tx_phase,
                     a.peak_bin, a.last_bin);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    build_twiddles();
    fill_count  = 0;
    skip_bins   = 6'd10;
    mismatches  = 0;
    cycle_count = 0;
    hold_left   = 0;
    stall_left  = 0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extreme_frame();
    test_backpressure();
    wait_drained();
    if (mismatches == 0 && expected_bins.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ fft_magnitude_phase_peak_top.f @@
hdl/fmpp_pkg.sv
hdl/fmpp_stream_if.sv
hdl/fmpp_front.sv
hdl/fmpp_queue.sv
hdl/fmpp_cordic.sv
hdl/fmpp_back.sv
hdl/fft_magnitude_phase_peak_top.sv
hdl/fmpp_checker.sv
bench/tb.sv
